// ===== src/crlq_pkg.sv =====
// Shared types and constants for the contrast range level quantizer.
`timescale 1ns / 1ps

package crlq_pkg;

    localparam int PIX_W      = 8;
    localparam int LEVEL_W    = 6;
    localparam int NLEV_W     = 7;
    localparam int ROW_W      = 9;
    localparam int RANGE_W    = PIX_W + 1;
    localparam int NUM_W      = RANGE_W + LEVEL_W - 1;
    localparam int PROD_W     = RANGE_W + NLEV_W;
    localparam int N_CELLS    = LEVEL_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ROW_W;

    localparam int MAX_LEVELS = 64;
    localparam int MAX_ROW    = 500;

    localparam logic [NLEV_W-1:0] NLEV_RESET = NLEV_W'(16);
    localparam logic [ROW_W-1:0]  ROW_RESET  = ROW_W'(60);
    localparam logic [PIX_W-1:0]  PIX_MAX    = '1;
    localparam logic [PIX_W-1:0]  PIX_MIN    = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_LEVELS = CFG_IDX_W'(0),
        CFG_ROW_WIDTH  = CFG_IDX_W'(1)
    } t_cfg_idx;

    // One slot of the divider chain.
    typedef struct packed {
        logic               valid;
        logic [NUM_W-1:0]   rem;
        logic [NUM_W-1:0]   dsh;
        logic [LEVEL_W-1:0] quo;
        logic               force_lv;
        logic [LEVEL_W-1:0] fval;
        logic               row_end;
    } t_cell_data;

    // Effective configuration, seen by the top level checks.
    typedef struct packed {
        logic [LEVEL_W-1:0] levels_m1;
        logic [ROW_W-1:0]   row_w;
    } t_eff;

endpackage

// ===== src/crlq_cell.sv =====
// One restoring-division cell: resolves one quotient bit and hands on.
`timescale 1ns / 1ps

module crlq_cell
    import crlq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_cell_data i_d,
    output t_cell_data o_d
);

    t_cell_data r_d;
    t_cell_data n_d;
    logic       w_ge;

    always_comb begin
        w_ge      = (i_d.rem >= i_d.dsh);
        n_d       = i_d;
        n_d.rem   = w_ge ? (i_d.rem - i_d.dsh) : i_d.rem;
        n_d.quo   = {i_d.quo[LEVEL_W-2:0], w_ge};
        n_d.dsh   = i_d.dsh >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ===== src/crlq_front.sv =====
// Entry stage: config registers, min/max tracking, column count, dividend setup.
`timescale 1ns / 1ps

module crlq_front
    import crlq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_accept,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_phase,
    input  logic                  i_frame_start,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cell_data            o_d,
    output t_eff                  o_eff
);

    logic [NLEV_W-1:0] r_num_levels;
    logic [ROW_W-1:0]  r_row_width;
    logic [PIX_W-1:0]  r_min, n_min;
    logic [PIX_W-1:0]  r_max, n_max;
    logic [ROW_W-1:0]  r_col, n_col;
    t_cell_data        r_d, n_d;

    logic [NLEV_W-1:0]  w_n;
    logic [ROW_W-1:0]   w_w;
    logic [RANGE_W-1:0] w_range;
    logic [RANGE_W-1:0] w_a;
    logic [PROD_W-1:0]  w_prod;
    logic               w_last;
    logic [PIX_W-1:0]   w_min_base;
    logic [PIX_W-1:0]   w_max_base;

    always_comb begin
        if (r_num_levels == '0) begin
            w_n = NLEV_W'(1);
        end else if (r_num_levels > NLEV_W'(MAX_LEVELS)) begin
            w_n = NLEV_W'(MAX_LEVELS);
        end else begin
            w_n = r_num_levels;
        end
        if (r_row_width == '0) begin
            w_w = ROW_W'(1);
        end else if (r_row_width > ROW_W'(MAX_ROW)) begin
            w_w = ROW_W'(MAX_ROW);
        end else begin
            w_w = r_row_width;
        end
    end

    always_comb begin
        w_range = RANGE_W'(r_max) - RANGE_W'(r_min) + RANGE_W'(1);
        w_a     = RANGE_W'(i_pixel) - RANGE_W'(r_min) + RANGE_W'(1);
        w_prod  = PROD_W'(w_a) * PROD_W'(w_n);
        w_last  = ({1'b0, r_col} + (ROW_W+1)'(1)) >= {1'b0, w_w};

        // frame start restarts the extremes before this pixel counts
        w_min_base = i_frame_start ? PIX_MAX : r_min;
        w_max_base = i_frame_start ? PIX_MIN : r_max;

        n_min = r_min;
        n_max = r_max;
        n_col = r_col;
        if (i_accept && !i_phase) begin
            n_min = (i_pixel < w_min_base) ? i_pixel : w_min_base;
            n_max = (i_pixel > w_max_base) ? i_pixel : w_max_base;
            if (i_frame_start) begin
                n_col = '0;
            end
        end else if (i_accept && i_phase) begin
            n_col = w_last ? '0 : (r_col + ROW_W'(1));
        end

        n_d          = '0;
        n_d.valid    = i_accept && i_phase;
        n_d.rem      = NUM_W'(w_prod - PROD_W'(1));
        n_d.dsh      = NUM_W'(w_range) << (LEVEL_W - 1);
        n_d.row_end  = w_last;
        if (r_max < r_min || i_pixel < r_min) begin
            n_d.force_lv = 1'b1;
            n_d.fval     = '0;
            n_d.rem      = '0;
        end else if (i_pixel > r_max) begin
            n_d.force_lv = 1'b1;
            n_d.fval     = LEVEL_W'(w_n - NLEV_W'(1));
            n_d.rem      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_levels <= NLEV_RESET;
            r_row_width  <= ROW_RESET;
            r_min        <= PIX_MAX;
            r_max        <= PIX_MIN;
            r_col        <= '0;
            r_d          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_NUM_LEVELS: r_num_levels <= NLEV_W'(i_cfg_data);
                    CFG_ROW_WIDTH:  r_row_width  <= ROW_W'(i_cfg_data);
                    default: ;
                endcase
            end
            r_min <= n_min;
            r_max <= n_max;
            r_col <= n_col;
            if (i_en) begin
                r_d <= n_d;
            end
        end
    end

    assign o_d             = r_d;
    assign o_eff.levels_m1 = LEVEL_W'(w_n - NLEV_W'(1));
    assign o_eff.row_w     = w_w;

endmodule

// ===== src/contrast_range_level_quantizer_core.sv =====
// Top level: entry stage followed by a chain of one-bit division cells.
// A render pixel's result passes the entry register, loaded when the pixel transfers,
// then six division cells, one quotient bit per cell.
// Throughput: one pixel per cycle; the whole chain holds while a finished
// result waits under output stall. Measure pixels give no result.
// Reset (synchronous, active low) empties the chain and restores the
// extremes, the column count and both config registers to their defaults.
`timescale 1ns / 1ps

module contrast_range_level_quantizer_core
    import crlq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_phase,
    input  logic                  i_frame_start,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [LEVEL_W-1:0]    o_level,
    output logic                  o_row_end,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cell_data w_chain [N_CELLS+1];
    t_eff       w_eff;
    logic       w_en;
    logic       w_accept;
    t_cell_data w_tail;

    // advance everything unless a finished result is held by the sink
    assign w_en        = !(w_tail.valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign w_accept    = i_in_valid && w_en;
    assign o_cfg_ready = 1'b1;

    crlq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_accept      (w_accept),
        .i_pixel       (i_pixel),
        .i_phase       (i_phase),
        .i_frame_start (i_frame_start),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_d           (w_chain[0]),
        .o_eff         (w_eff)
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        crlq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_d     (w_chain[g]),
            .o_d     (w_chain[g+1])
        );
    end

    assign w_tail      = w_chain[N_CELLS];
    assign o_out_valid = w_tail.valid;
    assign o_level     = w_tail.force_lv ? w_tail.fval : w_tail.quo;
    assign o_row_end   = w_tail.row_end;

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_level <= w_eff.levels_m1))
        else $error("level beyond the level count");

    a_unit_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && w_eff.row_w == ROW_W'(1)) |-> o_row_end)
        else $error("row of one pixel not closed");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_chain[N_CELLS-1].valid) |=> o_out_valid)
        else $error("result lost in last cell");

endmodule

// ===== dv/crlq_checker.sv =====
// Checker for the level quantizer: watches all channels, predicts levels and row ends, compares.
`timescale 1ns / 1ps

module crlq_checker
    import crlq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_phase,
    input  logic                  i_frame_start,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [LEVEL_W-1:0]    i_level,
    input  logic                  i_row_end,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results,
    output int                    o_row_ends
);

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               row_end;
    } t_level_out;

    t_level_out         level_q[$];
    t_level_out         want;
    t_level_out         got;
    logic [PIX_W-1:0]   lo_seen;
    logic [PIX_W-1:0]   hi_seen;
    int                 col_cnt;
    logic [NLEV_W-1:0]  cfg_levels;
    logic [ROW_W-1:0]   cfg_row;
    int                 eff_w;
    logic               is_last;

    initial begin
        o_errors   = 0;
        o_pending  = 0;
        o_results  = 0;
        o_row_ends = 0;
    end

    function automatic logic [LEVEL_W-1:0] quant_level(input logic [PIX_W-1:0] pix);
        int n;
        int span;
        int lv;
        n = int'(cfg_levels);
        if (n == 0) n = 1;
        if (n > MAX_LEVELS) n = MAX_LEVELS;
        // nothing measured yet, or pixel under the darkest bound
        if (hi_seen < lo_seen || pix < lo_seen) return '0;
        span = int'(hi_seen) - int'(lo_seen) + 1;
        lv = ((int'(pix) - int'(lo_seen) + 1) * n - 1) / span;
        if (lv > n - 1) lv = n - 1;
        return LEVEL_W'(lv);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lo_seen    = PIX_MAX;
            hi_seen    = PIX_MIN;
            col_cnt    = 0;
            cfg_levels = NLEV_RESET;
            cfg_row    = ROW_RESET;
            level_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.level   = i_level;
                got.row_end = i_row_end;
                o_results++;
                if (got.row_end) o_row_ends++;
                if (level_q.size() == 0) begin
                    $error("unexpected result: level %0d row_end %0b", got.level, got.row_end);
                    o_errors++;
                end else begin
                    want = level_q.pop_front();
                    if (got.level !== want.level) begin
                        $error("level: expected %0d, actual %0d", want.level, got.level);
                        o_errors++;
                    end
                    if (got.row_end !== want.row_end) begin
                        $error("row_end: expected %0b, actual %0b", want.row_end, got.row_end);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (!i_phase) begin
                    // restart the frame before taking this pixel
                    if (i_frame_start) begin
                        lo_seen = PIX_MAX;
                        hi_seen = PIX_MIN;
                        col_cnt = 0;
                    end
                    if (i_pixel < lo_seen) lo_seen = i_pixel;
                    if (i_pixel > hi_seen) hi_seen = i_pixel;
                end else begin
                    eff_w = int'(cfg_row);
                    if (eff_w == 0) eff_w = 1;
                    if (eff_w > MAX_ROW) eff_w = MAX_ROW;
                    is_last = (col_cnt + 1 >= eff_w);
                    col_cnt = is_last ? 0 : col_cnt + 1;
                    want.level   = quant_level(i_pixel);
                    want.row_end = is_last;
                    level_q.insert(level_q.size(), want);
                end
            end
            // a register write takes effect for the pixels after this edge
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NUM_LEVELS: cfg_levels = i_cfg_data[NLEV_W-1:0];
                    CFG_ROW_WIDTH:  cfg_row    = i_cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = level_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top: clock, reset, pixel and register stimulus, stall pattern and verdict.
`timescale 1ns / 1ps

module tb;
    import crlq_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_LIMIT   = 2000;
    localparam int ITEM_TARGET  = 1050;
    localparam int PHASE_ITEMS  = 85;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIX_W-1:0]      pix_in;
    logic                  phase_in;
    logic                  fs_in;
    logic                  out_valid;
    logic                  out_stall;
    logic [LEVEL_W-1:0]    level_out;
    logic                  row_end_out;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int err_cnt;
    int pend_cnt;
    int res_cnt;
    int row_end_cnt;
    int n_measure   = 0;
    int n_render    = 0;
    int n_cfg       = 0;
    int n_settings  = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int pick;
    logic stall_now = 1'b0;

    contrast_range_level_quantizer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_pixel       (pix_in),
        .i_phase       (phase_in),
        .i_frame_start (fs_in),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_level       (level_out),
        .o_row_end     (row_end_out),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    crlq_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_pixel       (pix_in),
        .i_phase       (phase_in),
        .i_frame_start (fs_in),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_level       (level_out),
        .i_row_end     (row_end_out),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_errors      (err_cnt),
        .o_pending     (pend_cnt),
        .o_results     (res_cnt),
        .o_row_ends    (row_end_cnt)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: stall runs, short free runs and occasional long free stretches
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                pick      = $urandom_range(0, 9);
                stall_now = (pick < 3);
                if (pick == 9) stall_left = $urandom_range(60, 120);
                else if (stall_now) stall_left = $urandom_range(1, 8);
                else stall_left = $urandom_range(1, 20);
            end
            stall_left--;
            out_stall <= stall_now;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic ph, input logic fs);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_valid <= 1'b1;
        pix_in   <= pix;
        phase_in <= ph;
        fs_in    <= fs;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if (ph) n_render++;
        else n_measure++;
    endtask

    // drop valid and let every pending result and any trailing measure pixel clear
    task automatic settle_block();
        @(negedge i_clk);
        in_valid  <= 1'b0;
        burst_left = 0;
        while (pend_cnt != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    task automatic run_frame();
        int lo;
        int hi;
        int n_meas;
        int n_rend;
        int pos_lo;
        int pos_hi;
        int kind;
        logic [PIX_W-1:0] pix;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            lo = 0;
            hi = 255;
        end else if (kind <= 2) begin
            lo = $urandom_range(0, 255);
            hi = lo + $urandom_range(0, 3);
            if (hi > 255) hi = 255;
        end else begin
            lo = $urandom_range(0, 255);
            hi = $urandom_range(lo, 255);
        end
        n_meas = $urandom_range(1, 8);
        n_rend = $urandom_range(1, 24);
        pos_lo = $urandom_range(0, n_meas - 1);
        pos_hi = $urandom_range(0, n_meas - 1);
        for (int k = 0; k < n_meas; k++) begin
            if (k == pos_lo) pix = PIX_W'(lo);
            else if (k == pos_hi) pix = PIX_W'(hi);
            else pix = PIX_W'($urandom_range(lo, hi));
            // a stray restart inside the measure pass now and then
            send_pixel(pix, 1'b0, (k == 0) || ($urandom_range(0, 39) == 0));
        end
        for (int k = 0; k < n_rend; k++) begin
            if ($urandom_range(0, 29) == 0)
                send_pixel(PIX_W'($urandom), 1'b0, 1'b0);
            if ($urandom_range(0, 4) == 0) pix = PIX_W'($urandom);
            else pix = PIX_W'($urandom_range(lo, hi));
            send_pixel(pix, 1'b1, $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] lv_data;
        logic [CFG_DATA_W-1:0] rw_data;
        int phase_end;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        pix_in    = '0;
        phase_in  = 1'b0;
        fs_in     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_NUM_LEVELS;
        cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // nothing measured yet: level 0, frame start on a render pixel ignored
        send_pixel(8'd0,   1'b1, 1'b1);
        send_pixel(8'd255, 1'b1, 1'b0);
        // full range
        send_pixel(8'd0,   1'b0, 1'b1);
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd0,   1'b1, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd128, 1'b1, 1'b0);
        // single-value range, pixels below and above it
        send_pixel(8'd100, 1'b0, 1'b1);
        send_pixel(8'd99,  1'b1, 1'b0);
        send_pixel(8'd100, 1'b1, 1'b0);
        send_pixel(8'd101, 1'b1, 1'b0);
        // restart mid-pass drops the earlier extremes
        send_pixel(8'd37,  1'b0, 1'b1);
        send_pixel(8'd200, 1'b0, 1'b0);
        send_pixel(8'd90,  1'b0, 1'b1);
        send_pixel(8'd170, 1'b0, 1'b0);
        send_pixel(8'd89,  1'b1, 1'b0);
        send_pixel(8'd90,  1'b1, 1'b0);
        send_pixel(8'd170, 1'b1, 1'b0);
        send_pixel(8'd171, 1'b1, 1'b0);
        send_pixel(8'h55,  1'b1, 1'b0);
        send_pixel(8'hAA,  1'b1, 1'b0);

        for (int ph = 0; n_measure + n_render < ITEM_TARGET; ph++) begin
            settle_block();
            case (ph)
                0: begin lv_data = 9'd1;   rw_data = 9'd1;   end
                1: begin lv_data = 9'd64;  rw_data = 9'd500; end
                2: begin lv_data = 9'h1FF; rw_data = 9'd3;   end
                3: begin lv_data = 9'd0;   rw_data = 9'd0;   end
                4: begin lv_data = 9'd65;  rw_data = 9'd511; end
                5: begin lv_data = 9'd2;   rw_data = 9'd7;   end
                6: begin lv_data = 9'd16;  rw_data = 9'd60;  end
                default: begin
                    lv_data = CFG_DATA_W'($urandom);
                    rw_data = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                          : CFG_DATA_W'($urandom_range(1, 40));
                end
            endcase
            write_reg(CFG_NUM_LEVELS, lv_data);
            write_reg(CFG_ROW_WIDTH, rw_data);
            n_settings++;
            if (ph == 0 || ph == 8) begin
                write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
                write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
            end
            // continue the previous row under the new width
            if (ph > 0) begin
                repeat ($urandom_range(1, 5)) send_pixel(PIX_W'($urandom), 1'b1, 1'b0);
            end
            phase_end = n_measure + n_render + PHASE_ITEMS;
            while (n_measure + n_render < phase_end && n_measure + n_render < ITEM_TARGET)
                run_frame();
        end

        settle_block();
        $display("Sent %0d pixels (%0d measure, %0d render) over %0d register settings, %0d writes.",
                 n_measure + n_render, n_measure, n_render, n_settings, n_cfg);
        $display("Checked %0d levels, %0d of them closing a row; %0d mismatches.",
                 res_cnt, row_end_cnt, err_cnt);
        if (err_cnt == 0 && pend_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/crlq_pkg.sv
src/crlq_cell.sv
src/crlq_front.sv
src/contrast_range_level_quantizer_core.sv
dv/crlq_checker.sv
dv/tb.sv
